>>> sv/stall_detect_homing_sequencer_core_defines.svh
// assertion macros for the stall detect homing sequencer core
// no dependencies; included by files that carry concurrent checks
`ifndef STALL_DETECT_HOMING_SEQUENCER_CORE_DEFINES_SVH
`define STALL_DETECT_HOMING_SEQUENCER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// property that must hold in every cycle outside reset
`define SDHS_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("sdhs check failed");
// condition implies outcome on the following edge
`define SDHS_ASSERT_NEXT(label, clk, rst_n, cond, outcome) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (outcome)) \
        else $error("sdhs check failed");
`else
`define SDHS_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define SDHS_ASSERT_NEXT(label, clk, rst_n, cond, outcome)
`endif

`endif

>>> sv/sdhs_pkg.sv
// shared types and constants for the stall detect homing sequencer
// no dependencies; imported by every module of the block
package sdhs_pkg;

    localparam int TIMER_W  = 20;
    localparam int CHECK_W  = 16;
    localparam int DUTY_W   = 16;
    localparam int ENC_W    = 32;
    localparam int RUN_W    = 8;
    localparam int CFG_W    = 20;
    localparam int CFG_IDX_W = 3;

    localparam logic [TIMER_W-1:0] SETTLE_SHORT = 20'd100;
    localparam logic [TIMER_W-1:0] SETTLE_LONG  = 20'd200;
    localparam logic [CHECK_W-1:0] CHECK_MAX    = 16'hFFFF;
    localparam logic [RUN_W-1:0]   RUN_MAX      = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] CFG_HOME_DUTY     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_DUTY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_LIMIT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_PERIOD  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL_DELTA   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL_CONFIRM = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_TICKS = 3'd7;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_SETTLE_A = 3'd1,
        PH_DRIVE    = 3'd2,
        PH_SETTLE_B = 3'd3,
        PH_BACKOFF  = 3'd4,
        PH_SETTLE_C = 3'd5
    } t_phase;

    typedef struct packed {
        logic [DUTY_W-1:0]  home_duty;
        logic [DUTY_W-1:0]  backoff_duty;
        logic [DUTY_W-1:0]  duty_limit;
        logic [TIMER_W-1:0] timeout_ticks;
        logic [CHECK_W-1:0] check_period;
        logic [DUTY_W-1:0]  stall_delta;
        logic [RUN_W-1:0]   stall_confirm;
        logic [DUTY_W-1:0]  backoff_ticks;
    } t_cfg;

    typedef struct packed {
        t_phase             phase;
        logic [TIMER_W-1:0] phase_timer;
        logic [CHECK_W-1:0] check_timer;
        logic [ENC_W-1:0]   last_sample;
        logic [RUN_W-1:0]   stall_run;
        logic               selected_motor;
        logic               homed_flag;
        logic               timeout_flag;
    } t_state;

    typedef struct packed {
        logic [DUTY_W-1:0] pwm_duty;
        logic              drive_forward;
        logic              motor_active;
        logic              clear_encoder;
        logic              clear_pid;
        logic              busy_res;
        logic              homed;
        logic              timed_out;
    } t_result;

    function automatic logic [DUTY_W-1:0] clamp_duty(input logic [DUTY_W-1:0] duty,
                                                     input logic [DUTY_W-1:0] limit);
        return (duty > limit) ? limit : duty;
    endfunction

endpackage

>>> sv/stall_detect_homing_sequencer_core.sv
// result: a result word is written into the result queue when its input word is accepted
// throughput: one word per cycle while the result queue has space; set by the state update and
//   the two-entry result queue, which keeps input ready while one result waits
// reset: synchronous active low; state returns to idle, registers to defaults
// depends on sdhs_pkg, sdhs_step, sdhs_outq and the defines header
`include "stall_detect_homing_sequencer_core_defines.svh"

module stall_detect_homing_sequencer_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wen,
    input  logic [sdhs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sdhs_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_command,
    input  logic                              i_motor_select,
    input  logic signed [sdhs_pkg::ENC_W-1:0] i_encoder_count,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [sdhs_pkg::DUTY_W-1:0]       o_pwm_duty,
    output logic                              o_drive_forward,
    output logic                              o_motor_active,
    output logic                              o_clear_encoder,
    output logic                              o_clear_pid,
    output logic                              o_busy_res,
    output logic                              o_homed,
    output logic                              o_timed_out
);
    import sdhs_pkg::*;

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result w_result;
    t_result w_out;
    logic    w_accept;

    assign w_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.home_duty     <= 16'd0;
            r_cfg.backoff_duty  <= 16'd0;
            r_cfg.duty_limit    <= 16'hFFFF;
            r_cfg.timeout_ticks <= 20'd10000;
            r_cfg.check_period  <= 16'd50;
            r_cfg.stall_delta   <= 16'd5;
            r_cfg.stall_confirm <= 8'd3;
            r_cfg.backoff_ticks <= 16'd100;
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                CFG_HOME_DUTY:     r_cfg.home_duty     <= i_cfg_wdata[DUTY_W-1:0];
                CFG_BACKOFF_DUTY:  r_cfg.backoff_duty  <= i_cfg_wdata[DUTY_W-1:0];
                CFG_DUTY_LIMIT:    r_cfg.duty_limit    <= i_cfg_wdata[DUTY_W-1:0];
                CFG_TIMEOUT_TICKS: r_cfg.timeout_ticks <= i_cfg_wdata[TIMER_W-1:0];
                CFG_CHECK_PERIOD:  r_cfg.check_period  <= i_cfg_wdata[CHECK_W-1:0];
                CFG_STALL_DELTA:   r_cfg.stall_delta   <= i_cfg_wdata[DUTY_W-1:0];
                CFG_STALL_CONFIRM: r_cfg.stall_confirm <= i_cfg_wdata[RUN_W-1:0];
                CFG_BACKOFF_TICKS: r_cfg.backoff_ticks <= i_cfg_wdata[DUTY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    sdhs_step u_step (
        .i_cfg          (r_cfg),
        .i_state        (r_state),
        .i_command      (i_command),
        .i_motor_select (i_motor_select),
        .i_encoder      ($unsigned(i_encoder_count)),
        .o_state        (n_state),
        .o_result       (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase          <= PH_IDLE;
            r_state.phase_timer    <= '0;
            r_state.check_timer    <= '0;
            r_state.last_sample    <= '0;
            r_state.stall_run      <= '0;
            r_state.selected_motor <= 1'b0;
            r_state.homed_flag     <= 1'b0;
            r_state.timeout_flag   <= 1'b0;
        end else if (w_accept) begin
            r_state <= n_state;
        end
    end

    sdhs_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_word  (w_result),
        .o_space (o_ready),
        .i_ready (i_ready),
        .o_valid (o_valid),
        .o_word  (w_out)
    );

    assign o_pwm_duty      = w_out.pwm_duty;
    assign o_drive_forward = w_out.drive_forward;
    assign o_motor_active  = w_out.motor_active;
    assign o_clear_encoder = w_out.clear_encoder;
    assign o_clear_pid     = w_out.clear_pid;
    assign o_busy_res      = w_out.busy_res;
    assign o_homed         = w_out.homed;
    assign o_timed_out     = w_out.timed_out;

    // homed only ever stands in idle
    `SDHS_ASSERT_ALWAYS(a_homed_idle, i_clk, i_rst_n, !r_state.homed_flag || (r_state.phase == PH_IDLE))
    // success and timeout are exclusive
    `SDHS_ASSERT_ALWAYS(a_flags_excl, i_clk, i_rst_n, !(r_state.homed_flag && r_state.timeout_flag))
    // an accepted word always yields a pending result
    `SDHS_ASSERT_NEXT(a_accept_out, i_clk, i_rst_n, w_accept, o_valid)

endmodule

>>> sv/sdhs_step.sv
// per-word sequencer update: next state and result word from current state
// depends on sdhs_pkg
module sdhs_step (
    input  sdhs_pkg::t_cfg                 i_cfg,
    input  sdhs_pkg::t_state               i_state,
    input  logic                           i_command,
    input  logic                           i_motor_select,
    input  logic [sdhs_pkg::ENC_W-1:0]     i_encoder,
    output sdhs_pkg::t_state               o_state,
    output sdhs_pkg::t_result              o_result
);
    import sdhs_pkg::*;

    logic [TIMER_W-1:0] w_timer_inc;
    logic [CHECK_W-1:0] w_check_inc;
    logic [ENC_W-1:0]   w_diff;
    logic [ENC_W-1:0]   w_mag;
    logic               w_stalled;
    logic [RUN_W-1:0]   w_run_next;
    logic               w_pulse;

    assign w_timer_inc = i_state.phase_timer + {{(TIMER_W-1){1'b0}}, 1'b1};
    assign w_check_inc = (i_state.check_timer < CHECK_MAX) ?
                         i_state.check_timer + {{(CHECK_W-1){1'b0}}, 1'b1} :
                         i_state.check_timer;
    assign w_diff    = i_encoder - i_state.last_sample;
    assign w_mag     = w_diff[ENC_W-1] ? ({ENC_W{1'b0}} - w_diff) : w_diff;
    assign w_stalled = w_mag < {{(ENC_W-DUTY_W){1'b0}}, i_cfg.stall_delta};
    assign w_run_next = !w_stalled ? {RUN_W{1'b0}} :
                        (i_state.stall_run == RUN_MAX) ? RUN_MAX :
                        i_state.stall_run + {{(RUN_W-1){1'b0}}, 1'b1};

    // next state
    always_comb begin
        o_state = i_state;
        w_pulse = 1'b0;
        if (i_command) begin
            if (i_state.phase == PH_IDLE) begin
                o_state.selected_motor = i_motor_select;
                o_state.homed_flag     = 1'b0;
                o_state.timeout_flag   = 1'b0;
                o_state.phase          = PH_SETTLE_A;
                o_state.phase_timer    = '0;
                w_pulse                = 1'b1;
            end
        end else begin
            case (i_state.phase)
                PH_SETTLE_A: begin
                    o_state.phase_timer = w_timer_inc;
                    if (w_timer_inc >= SETTLE_SHORT) begin
                        o_state.phase       = PH_DRIVE;
                        o_state.phase_timer = '0;
                        o_state.check_timer = '0;
                        o_state.stall_run   = '0;
                        o_state.last_sample = i_encoder;
                    end
                end
                PH_DRIVE: begin
                    if (i_state.phase_timer >= i_cfg.timeout_ticks) begin
                        o_state.phase        = PH_IDLE;
                        o_state.timeout_flag = 1'b1;
                        o_state.homed_flag   = 1'b0;
                        o_state.phase_timer  = '0;
                    end else begin
                        o_state.phase_timer = w_timer_inc;
                        o_state.check_timer = w_check_inc;
                        if (w_check_inc >= i_cfg.check_period) begin
                            o_state.check_timer = '0;
                            o_state.last_sample = i_encoder;
                            o_state.stall_run   = w_run_next;
                            if (w_run_next >= i_cfg.stall_confirm) begin
                                o_state.phase       = PH_SETTLE_B;
                                o_state.phase_timer = '0;
                            end
                        end
                    end
                end
                PH_SETTLE_B: begin
                    o_state.phase_timer = w_timer_inc;
                    if (w_timer_inc >= SETTLE_SHORT) begin
                        o_state.phase_timer = '0;
                        o_state.phase = (i_cfg.backoff_ticks == '0) ? PH_SETTLE_C : PH_BACKOFF;
                    end
                end
                PH_BACKOFF: begin
                    o_state.phase_timer = w_timer_inc;
                    if (w_timer_inc >= {{(TIMER_W-DUTY_W){1'b0}}, i_cfg.backoff_ticks}) begin
                        o_state.phase       = PH_SETTLE_C;
                        o_state.phase_timer = '0;
                    end
                end
                PH_SETTLE_C: begin
                    o_state.phase_timer = w_timer_inc;
                    if (w_timer_inc >= SETTLE_LONG) begin
                        o_state.phase       = PH_IDLE;
                        o_state.phase_timer = '0;
                        o_state.homed_flag  = 1'b1;
                        w_pulse             = 1'b1;
                    end
                end
                default: begin
                    o_state.phase = PH_IDLE;
                end
            endcase
        end
    end

    // result word
    always_comb begin
        o_result.pwm_duty      = '0;
        o_result.drive_forward = 1'b1;
        case (o_state.phase)
            PH_DRIVE: begin
                o_result.pwm_duty = clamp_duty(i_cfg.home_duty, i_cfg.duty_limit);
            end
            PH_BACKOFF: begin
                o_result.pwm_duty      = clamp_duty(i_cfg.backoff_duty, i_cfg.duty_limit);
                o_result.drive_forward = 1'b0;
            end
            PH_SETTLE_C: begin
                o_result.drive_forward = 1'b0;
            end
            PH_IDLE: begin
                o_result.drive_forward = !o_state.homed_flag;
            end
            default: begin
                o_result.drive_forward = 1'b1;
            end
        endcase
        o_result.motor_active  = o_state.selected_motor;
        o_result.clear_encoder = w_pulse;
        o_result.clear_pid     = w_pulse;
        o_result.busy_res      = (o_state.phase != PH_IDLE);
        o_result.homed         = o_state.homed_flag;
        o_result.timed_out     = o_state.timeout_flag;
    end

endmodule

>>> sv/sdhs_outq.sv
// two-entry result queue: output register plus skid slot
// depends on sdhs_pkg for the result word type
module sdhs_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  sdhs_pkg::t_result   i_word,
    output logic                o_space,
    input  logic                i_ready,
    output logic                o_valid,
    output sdhs_pkg::t_result   o_word
);
    import sdhs_pkg::*;

    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_result    r_slot0;
    t_result    r_slot1;
    logic       w_pop;

    assign w_pop   = (r_cnt != 2'd0) && i_ready;
    assign o_space = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_word  = r_slot0;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !w_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && w_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_cnt == 2'd2) begin
            if (w_pop) begin
                r_slot0 <= r_slot1;
            end
        end else if (i_push) begin
            if (r_cnt == 2'd0 || w_pop) begin
                r_slot0 <= i_word;
            end else begin
                r_slot1 <= i_word;
            end
        end
    end

endmodule

>>> tb/sv/stall_detect_homing_sequencer_core_tb.sv
// self-checking bench for stall_detect_homing_sequencer_core: directed table, then random
// homing runs under several register settings, each word checked against a fixed word or local predictor
// depends on sdhs_pkg and the core; needs no files or arguments
module stall_detect_homing_sequencer_core_tb;
    import sdhs_pkg::*;

    localparam int DIR_ROWS    = 18;
    localparam int SETTINGS_N  = 8;
    localparam int PHASE_WORDS = 91;
    localparam int STALL_LIMIT = 2000;

    localparam t_result RES_IDLE    = '{pwm_duty: 16'd0, drive_forward: 1'b1, default: 1'b0};
    localparam t_result RES_START_R = '{pwm_duty: 16'd0, drive_forward: 1'b1,
                                        motor_active: 1'b1, clear_encoder: 1'b1,
                                        clear_pid: 1'b1, busy_res: 1'b1, default: 1'b0};
    localparam t_result RES_BUSY_R  = '{pwm_duty: 16'd0, drive_forward: 1'b1,
                                        motor_active: 1'b1, busy_res: 1'b1, default: 1'b0};

    typedef struct {
        logic        cmd;
        logic        motor;
        logic [31:0] enc;
        logic        fixed;
        t_result     res;
    } t_dir_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx = '0;
    logic [CFG_W-1:0]        i_cfg_wdata = '0;
    logic                    i_valid = 1'b0;
    logic                    o_ready;
    logic                    i_command = 1'b0;
    logic                    i_motor_select = 1'b0;
    logic signed [ENC_W-1:0] i_encoder_count = '0;
    logic                    o_valid;
    logic                    i_ready = 1'b0;
    logic [DUTY_W-1:0]       o_pwm_duty;
    logic                    o_drive_forward;
    logic                    o_motor_active;
    logic                    o_clear_encoder;
    logic                    o_clear_pid;
    logic                    o_busy_res;
    logic                    o_homed;
    logic                    o_timed_out;

    stall_detect_homing_sequencer_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wen       (i_cfg_wen),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_command       (i_command),
        .i_motor_select  (i_motor_select),
        .i_encoder_count (i_encoder_count),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_pwm_duty      (o_pwm_duty),
        .o_drive_forward (o_drive_forward),
        .o_motor_active  (o_motor_active),
        .o_clear_encoder (o_clear_encoder),
        .o_clear_pid     (o_clear_pid),
        .o_busy_res      (o_busy_res),
        .o_homed         (o_homed),
        .o_timed_out     (o_timed_out)
    );

    t_state      homing_st;
    t_cfg        homing_cfg;
    t_result     drive_words_q [$];
    t_dir_row    dir_table [DIR_ROWS];
    logic [31:0] enc_pos;
    int          move_left;
    int          in_burst;
    int          out_burst;
    int          mismatches;
    int          words_sent;
    int          words_checked;
    int          homed_runs;
    int          timeout_runs;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic int draw_gap(ref int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            burst = $urandom_range(10, 40);
        return $urandom_range(0, 12);
    endfunction

    function automatic logic [DUTY_W-1:0] limit_duty(input logic [DUTY_W-1:0] d);
        return (d > homing_cfg.duty_limit) ? homing_cfg.duty_limit : d;
    endfunction

    function automatic t_result next_drive_word(input logic cmd, input logic motor,
                                                input logic [31:0] enc);
        t_result     r;
        logic        pulse;
        logic [31:0] delta;
        logic [31:0] mag;
        pulse = 1'b0;
        if (cmd) begin
            if (homing_st.phase == PH_IDLE) begin
                homing_st.selected_motor = motor;
                homing_st.homed_flag     = 1'b0;
                homing_st.timeout_flag   = 1'b0;
                homing_st.phase          = PH_SETTLE_A;
                homing_st.phase_timer    = '0;
                pulse = 1'b1;
            end
        end else begin
            case (homing_st.phase)
                PH_SETTLE_A: begin
                    homing_st.phase_timer = homing_st.phase_timer + 1'b1;
                    if (homing_st.phase_timer >= SETTLE_SHORT) begin
                        homing_st.phase       = PH_DRIVE;
                        homing_st.phase_timer = '0;
                        homing_st.check_timer = '0;
                        homing_st.stall_run   = '0;
                        homing_st.last_sample = enc;
                    end
                end
                PH_DRIVE: begin
                    if (homing_st.phase_timer >= homing_cfg.timeout_ticks) begin
                        homing_st.phase        = PH_IDLE;
                        homing_st.timeout_flag = 1'b1;
                        homing_st.homed_flag   = 1'b0;
                        homing_st.phase_timer  = '0;
                        timeout_runs++;
                    end else begin
                        homing_st.phase_timer = homing_st.phase_timer + 1'b1;
                        if (homing_st.check_timer != CHECK_MAX)
                            homing_st.check_timer = homing_st.check_timer + 1'b1;
                        if (homing_st.check_timer >= homing_cfg.check_period) begin
                            delta = enc - homing_st.last_sample;
                            mag   = delta[31] ? (32'd0 - delta) : delta;
                            homing_st.check_timer = '0;
                            homing_st.last_sample = enc;
                            if (mag < {16'd0, homing_cfg.stall_delta}) begin
                                if (homing_st.stall_run != RUN_MAX)
                                    homing_st.stall_run = homing_st.stall_run + 1'b1;
                            end else begin
                                homing_st.stall_run = '0;
                            end
                            if (homing_st.stall_run >= homing_cfg.stall_confirm) begin
                                homing_st.phase       = PH_SETTLE_B;
                                homing_st.phase_timer = '0;
                            end
                        end
                    end
                end
                PH_SETTLE_B: begin
                    homing_st.phase_timer = homing_st.phase_timer + 1'b1;
                    if (homing_st.phase_timer >= SETTLE_SHORT) begin
                        homing_st.phase_timer = '0;
                        homing_st.phase = (homing_cfg.backoff_ticks == '0) ? PH_SETTLE_C
                                                                             : PH_BACKOFF;
                    end
                end
                PH_BACKOFF: begin
                    homing_st.phase_timer = homing_st.phase_timer + 1'b1;
                    if (homing_st.phase_timer >= {4'd0, homing_cfg.backoff_ticks}) begin
                        homing_st.phase       = PH_SETTLE_C;
                        homing_st.phase_timer = '0;
                    end
                end
                PH_SETTLE_C: begin
                    homing_st.phase_timer = homing_st.phase_timer + 1'b1;
                    if (homing_st.phase_timer >= SETTLE_LONG) begin
                        homing_st.phase       = PH_IDLE;
                        homing_st.phase_timer = '0;
                        homing_st.homed_flag  = 1'b1;
                        pulse = 1'b1;
                        homed_runs++;
                    end
                end
                default: ;
            endcase
        end

        r = RES_IDLE;
        if (homing_st.phase == PH_DRIVE) begin
            r.pwm_duty = limit_duty(homing_cfg.home_duty);
        end else if (homing_st.phase == PH_BACKOFF) begin
            r.pwm_duty      = limit_duty(homing_cfg.backoff_duty);
            r.drive_forward = 1'b0;
        end else if (homing_st.phase == PH_SETTLE_C ||
                     (homing_st.phase == PH_IDLE && homing_st.homed_flag)) begin
            r.drive_forward = 1'b0;
        end
        r.motor_active  = homing_st.selected_motor;
        r.clear_encoder = pulse;
        r.clear_pid     = pulse;
        r.busy_res      = (homing_st.phase != PH_IDLE);
        r.homed         = homing_st.homed_flag;
        r.timed_out     = homing_st.timeout_flag;
        return r;
    endfunction

    task automatic send_word(input logic cmd, input logic motor, input logic [31:0] enc,
                             input logic fixed, input t_result fixed_res);
        int      gap;
        t_result pred;
        gap = draw_gap(in_burst);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_command       <= cmd;
        i_motor_select  <= motor;
        i_encoder_count <= enc;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pred = next_drive_word(cmd, motor, enc);
        drive_words_q.push_back(fixed ? fixed_res : pred);
        words_sent++;
    endtask

    task automatic hold_input();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
    endtask

    task automatic write_settings(input t_cfg c);
        while (drive_words_q.size() != 0) @(posedge i_clk);
        repeat (2) @(negedge i_clk);
        write_reg(CFG_HOME_DUTY,     CFG_W'(c.home_duty));
        write_reg(CFG_BACKOFF_DUTY,  CFG_W'(c.backoff_duty));
        write_reg(CFG_DUTY_LIMIT,    CFG_W'(c.duty_limit));
        write_reg(CFG_TIMEOUT_TICKS, CFG_W'(c.timeout_ticks));
        write_reg(CFG_CHECK_PERIOD,  CFG_W'(c.check_period));
        write_reg(CFG_STALL_DELTA,   CFG_W'(c.stall_delta));
        write_reg(CFG_STALL_CONFIRM, CFG_W'(c.stall_confirm));
        write_reg(CFG_BACKOFF_TICKS, CFG_W'(c.backoff_ticks));
        @(negedge i_clk);
        i_cfg_wen <= 1'b0;
        homing_cfg = c;
    endtask

    function automatic t_cfg mk_cfg(input int hd, input int bd, input int lim, input int tmo,
                                    input int cp, input int sd, input int sc, input int bt);
        t_cfg c;
        c.home_duty     = DUTY_W'(hd);
        c.backoff_duty  = DUTY_W'(bd);
        c.duty_limit    = DUTY_W'(lim);
        c.timeout_ticks = TIMER_W'(tmo);
        c.check_period  = CHECK_W'(cp);
        c.stall_delta   = DUTY_W'(sd);
        c.stall_confirm = RUN_W'(sc);
        c.backoff_ticks = DUTY_W'(bt);
        return c;
    endfunction

    // moving encoder for a random stretch of the drive, then a near-stationary one
    task automatic run_random_phase(input int n_words);
        logic        cmd;
        logic        motor;
        logic [31:0] enc_val;
        logic [31:0] step;
        int          r;
        for (int k = 0; k < n_words; k++) begin
            r     = $urandom_range(0, 99);
            motor = 1'($urandom_range(0, 1));
            cmd   = 1'b0;
            if (homing_st.phase == PH_IDLE && r < 60) begin
                cmd       = 1'b1;
                enc_val   = $urandom;
                move_left = $urandom_range(0, 60);
            end else if (r < 2) begin
                cmd     = 1'b1;
                enc_val = $urandom;
            end else if (r < 5) begin
                if ($urandom_range(0, 3) == 0)
                    enc_pos = enc_pos + 32'h8000_0000;
                else
                    enc_pos = $urandom;
                enc_val = enc_pos;
            end else begin
                if (homing_st.phase == PH_DRIVE && move_left == 0) begin
                    if (homing_cfg.stall_delta == '0 || $urandom_range(0, 2) != 0)
                        step = '0;
                    else
                        step = $urandom_range(0, int'(homing_cfg.stall_delta) - 1);
                end else begin
                    step = 32'(homing_cfg.stall_delta) + $urandom_range(0, 5000);
                    if (homing_st.phase == PH_DRIVE)
                        move_left--;
                end
                if ($urandom_range(0, 1))
                    step = 32'd0 - step;
                enc_pos = enc_pos + step;
                enc_val = enc_pos;
            end
            send_word(cmd, motor, enc_val, 1'b0, '0);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
        end
    endtask

    initial begin : result_side
        int      gap;
        t_result exp_r;
        forever begin
            gap = draw_gap(out_burst);
            @(negedge i_clk);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            if (drive_words_q.size() == 0) begin
                mismatches++;
                $display("%0t: result word with nothing expected, got duty %0h busy %0b",
                         $time, o_pwm_duty, o_busy_res);
            end else begin
                exp_r = drive_words_q.pop_front();
                check_field("pwm_duty",      exp_r.pwm_duty,      o_pwm_duty);
                check_field("drive_forward", exp_r.drive_forward, o_drive_forward);
                check_field("motor_active",  exp_r.motor_active,  o_motor_active);
                check_field("clear_encoder", exp_r.clear_encoder, o_clear_encoder);
                check_field("clear_pid",     exp_r.clear_pid,     o_clear_pid);
                check_field("busy_res",      exp_r.busy_res,      o_busy_res);
                check_field("homed",         exp_r.homed,         o_homed);
                check_field("timed_out",     exp_r.timed_out,     o_timed_out);
                words_checked++;
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        t_cfg c;
        homing_st  = '0;
        homing_cfg = mk_cfg(0, 0, 65535, 10000, 50, 5, 3, 100);
        enc_pos    = '0;
        move_left  = 0;
        in_burst   = 0;
        out_burst  = 0;
        mismatches = 0;
        words_sent = 0;
        words_checked = 0;
        homed_runs    = 0;
        timeout_runs  = 0;

        dir_table = '{
            '{1'b0, 1'b0, 32'h0000_0000, 1'b1, RES_IDLE},
            '{1'b0, 1'b1, 32'h7FFF_FFFF, 1'b1, RES_IDLE},
            '{1'b0, 1'b0, 32'h8000_0000, 1'b1, RES_IDLE},
            '{1'b0, 1'b1, 32'hFFFF_FFFF, 1'b1, RES_IDLE},
            '{1'b1, 1'b1, 32'h0000_0000, 1'b1, RES_START_R},
            '{1'b1, 1'b0, 32'h5555_5555, 1'b1, RES_BUSY_R},
            '{1'b0, 1'b0, 32'hAAAA_AAAA, 1'b0, '0},
            '{1'b0, 1'b1, 32'h0000_0001, 1'b0, '0},
            '{1'b0, 1'b0, 32'h8000_0000, 1'b0, '0},
            '{1'b0, 1'b1, 32'h7FFF_FFFF, 1'b0, '0},
            '{1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0, '0},
            '{1'b0, 1'b1, 32'h1234_5678, 1'b0, '0},
            '{1'b0, 1'b0, 32'hEDCB_A987, 1'b0, '0},
            '{1'b0, 1'b1, 32'hFFFF_0000, 1'b0, '0},
            '{1'b0, 1'b0, 32'h0000_FFFF, 1'b0, '0},
            '{1'b0, 1'b1, 32'h8000_0001, 1'b0, '0},
            '{1'b1, 1'b1, 32'h7FFF_FFFF, 1'b1, RES_BUSY_R},
            '{1'b0, 1'b0, 32'h0000_0000, 1'b0, '0}
        };

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < DIR_ROWS; n++)
            send_word(dir_table[n].cmd, dir_table[n].motor, dir_table[n].enc,
                      dir_table[n].fixed, dir_table[n].res);
        hold_input();

        for (int s = 0; s < SETTINGS_N; s++) begin
            case (s)
                0: c = mk_cfg($urandom_range(0, 65535), $urandom_range(0, 65535),
                              65535, 10000, 1, 5, 1, 20);
                1: c = mk_cfg($urandom_range(0, 65535), $urandom_range(0, 65535),
                              1000, 1048575, 3, 100, 3, 0);
                2: c = mk_cfg(65535, 65535, 0, 0, 1, 5, 1, 10);
                3: c = mk_cfg($urandom_range(0, 65535), $urandom_range(0, 65535),
                              0, 25, 4, 3, 2, 5);
                4: c = mk_cfg($urandom_range(0, 65535), $urandom_range(0, 65535),
                              40000, 500, 0, 65535, 0, 1);
                5: c = mk_cfg(65535, 65535, 65535, 400, 65535, 0, 255, 65535);
                6: c = mk_cfg($urandom_range(0, 65535), $urandom_range(0, 65535),
                              30000, 1000, 1, 50, 255, 3);
                default: c = mk_cfg($urandom_range(0, 65535), $urandom_range(0, 65535),
                                    65535, 10000, 2, 20, 4, 30);
            endcase
            write_settings(c);
            run_random_phase(PHASE_WORDS);
            hold_input();
        end

        while (drive_words_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("%0d words sent and %0d results checked over %0d register settings",
                 words_sent, words_checked, SETTINGS_N);
        $display("%0d homing runs finished homed, %0d ended by timeout, %0d mismatches",
                 homed_runs, timeout_runs, mismatches);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/sdhs_pkg.sv
sv/sdhs_step.sv
sv/sdhs_outq.sv
sv/stall_detect_homing_sequencer_core.sv
tb/sv/stall_detect_homing_sequencer_core_tb.sv
